FILE: rtl/ohist_pkg.sv
// Shared types and constants of the overlapping-bin weighted histogram.
// Used by ohist_div, ohist_dp, ohist_ctrl and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package ohist_pkg;

  // Sizes of the block.
  localparam int NUM_BINS    = 64;
  localparam int MAX_SAMPLES = 64;

  // Field widths.
  localparam int VAL_W       = 20;   // signed Q4.16 values
  localparam int WT_W        = 24;   // unsigned Q8.16 weights
  localparam int ACC_W       = 32;   // bin sums and set total
  localparam int DIVR_W      = 13;   // width divisor register
  localparam int BIN_IDX_W   = 6;    // bin number port
  localparam int FRAC_W      = 17;   // Q0.16 fraction with room for one
  localparam int FRAC_SHIFT  = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = VAL_W;

  // Internal widths.
  localparam int POS_W       = VAL_W + 1;           // starts, width, step
  localparam int CMP_W       = POS_W + 2;           // edge compares and center sum
  localparam int CTR_W       = CMP_W - 1;           // center before saturation
  localparam int NUM_W       = ACC_W + FRAC_SHIFT + 1;
  localparam int CNT_W       = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int DIV_W       = 32;
  localparam int DIV_STEPS_W = 6;

  // The start spacing divides a 20-bit magnitude by NUM_BINS - 1 through a
  // multiplication with the rounded-up reciprocal; with a 26-bit shift the
  // truncated product equals the quotient for every such magnitude.
  localparam int STEP_SHIFT   = 26;
  localparam int STEP_RECIP_W = STEP_SHIFT + 1;
  localparam logic [STEP_RECIP_W-1:0] STEP_RECIP =
    STEP_RECIP_W'((2 ** STEP_SHIFT + NUM_BINS - 2) / (NUM_BINS - 1));

  localparam logic [POS_W-1:0] EDGE_WIDEN = POS_W'(7);
  localparam logic [FRAC_W-1:0] FRAC_ONE  = FRAC_W'(65536);
  localparam logic signed [CTR_W-1:0] CTR_MIN = CTR_W'(-(2 ** (VAL_W - 1)));
  localparam logic signed [CTR_W-1:0] CTR_MAX = CTR_W'(2 ** (VAL_W - 1) - 1);

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH_DIV  = 2'd2;

  // Register reset values.
  localparam logic [VAL_W-1:0]  RANGE_LOW_RST  = VAL_W'(0);
  localparam logic [VAL_W-1:0]  RANGE_HIGH_RST = VAL_W'(72090);
  localparam logic [DIVR_W-1:0] WIDTH_DIV_RST  = DIVR_W'(10);

  // Operand set for the shared divider.
  typedef enum logic [1:0] {
    DIV_SEL_WIDTH,
    DIV_SEL_FRAC
  } div_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                 accum;
    logic                 div_start;
    div_sel_e             div_sel;
    logic                 cap_width;
    logic                 cap_step;
    logic                 fill_reset;
    logic                 fill_shift;
    logic                 out_load;
    logic                 last_load;
    logic [BIN_IDX_W-1:0] bin_idx;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

FILE: rtl/ohist_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on ohist_pkg for its widths.
`timescale 1ns / 1ps
`default_nettype none

module ohist_div (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [ohist_pkg::DIV_W-1:0]        rem_init_i,
  input  logic [ohist_pkg::DIV_W-1:0]        dvd_i,
  input  logic [ohist_pkg::DIV_W-1:0]        dsr_i,
  input  logic [ohist_pkg::DIV_STEPS_W-1:0]  steps_i,
  output logic                               done_o,
  output logic [ohist_pkg::DIV_W-1:0]        quo_o
);

  logic [ohist_pkg::DIV_W-1:0]       rem_q, rem_d;
  logic [ohist_pkg::DIV_W-1:0]       dvd_q;
  logic [ohist_pkg::DIV_W-1:0]       dsr_q;
  logic [ohist_pkg::DIV_W-1:0]       quo_q;
  logic [ohist_pkg::DIV_STEPS_W-1:0] cnt_q;
  logic                              busy_q;
  logic                              done_q;
  logic [ohist_pkg::DIV_W:0]         shifted;
  logic [ohist_pkg::DIV_W+1:0]       diff;
  logic                              fits;

  // The remainder stays below the divisor, so the shifted value is below twice it.
  always_comb begin
    shifted = {rem_q, dvd_q[ohist_pkg::DIV_W-1]};
    diff    = {1'b0, shifted} - {2'b00, dsr_q};
    fits    = !diff[ohist_pkg::DIV_W+1];
    rem_d   = fits ? diff[ohist_pkg::DIV_W-1:0] : shifted[ohist_pkg::DIV_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= steps_i;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == ohist_pkg::DIV_STEPS_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= rem_init_i;
      dvd_q <= dvd_i;
      dsr_q <= dsr_i;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= rem_d;
      dvd_q <= {dvd_q[ohist_pkg::DIV_W-2:0], 1'b0};
      quo_q <= {quo_q[ohist_pkg::DIV_W-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

`default_nettype wire

FILE: rtl/ohist_dp.sv
// Datapath: configuration registers, bin cells with their sums, shared divider
// and the output register. Depends on ohist_pkg and ohist_div.
`timescale 1ns / 1ps
`default_nettype none

module ohist_dp (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [ohist_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [ohist_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  input  logic [ohist_pkg::VAL_W-1:0]            sample_value_i,
  input  logic [ohist_pkg::WT_W-1:0]             sample_weight_i,
  input  ohist_pkg::cmd_t                        cmd_i,
  output ohist_pkg::sts_t                        sts_o,
  input  logic                                   out_ready_i,
  output logic                                   out_valid_o,
  output logic [ohist_pkg::BIN_IDX_W-1:0]        bin_number_o,
  output logic [ohist_pkg::VAL_W-1:0]            bin_center_o,
  output logic [ohist_pkg::FRAC_W-1:0]           bin_fraction_o,
  output logic                                   last_bin_o
);

  localparam int NB = ohist_pkg::NUM_BINS;

  logic [ohist_pkg::VAL_W-1:0]  range_low_q;
  logic [ohist_pkg::VAL_W-1:0]  range_high_q;
  logic [ohist_pkg::DIVR_W-1:0] width_div_q;

  logic [ohist_pkg::POS_W-1:0] w_q;
  logic [ohist_pkg::POS_W-1:0] step_q;
  logic [ohist_pkg::POS_W-1:0] run_q;
  logic [ohist_pkg::POS_W-1:0] start_q [NB];
  logic [ohist_pkg::ACC_W-1:0] acc_q   [NB];
  logic [ohist_pkg::ACC_W-1:0] total_q;
  logic [NB-1:0]               hit;

  logic [ohist_pkg::POS_W-1:0]  span;
  logic                         span_neg;
  logic [ohist_pkg::POS_W-1:0]  span_abs;
  logic [ohist_pkg::POS_W:0]    rest;
  logic                         rest_neg;
  logic [ohist_pkg::POS_W:0]    rest_abs;
  logic [ohist_pkg::VAL_W+ohist_pkg::STEP_RECIP_W-1:0] step_prod;
  logic [ohist_pkg::POS_W-1:0]  step_mag;
  logic [ohist_pkg::DIVR_W-1:0] div_eff;
  logic [ohist_pkg::NUM_W-1:0]  num;
  logic [ohist_pkg::POS_W-1:0]  quo_mag;

  logic [ohist_pkg::DIV_W-1:0]       div_rem;
  logic [ohist_pkg::DIV_W-1:0]       div_dvd;
  logic [ohist_pkg::DIV_W-1:0]       div_dsr;
  logic [ohist_pkg::DIV_STEPS_W-1:0] div_steps;
  logic                              div_done;
  logic [ohist_pkg::DIV_W-1:0]       div_quo;

  logic [ohist_pkg::CMP_W-1:0]  ctr_sum;
  logic [ohist_pkg::CTR_W-1:0]  ctr_raw;
  logic [ohist_pkg::VAL_W-1:0]  ctr_sat;
  logic [ohist_pkg::FRAC_W-1:0] frac_q17;
  logic [ohist_pkg::FRAC_W-1:0] frac_val;

  logic                         out_valid_q;
  logic [ohist_pkg::BIN_IDX_W-1:0] bin_number_q;
  logic [ohist_pkg::VAL_W-1:0]  bin_center_q;
  logic [ohist_pkg::FRAC_W-1:0] bin_fraction_q;
  logic                         last_bin_q;

  function automatic logic [ohist_pkg::ACC_W-1:0] sat_add(
    input logic [ohist_pkg::ACC_W-1:0] a,
    input logic [ohist_pkg::ACC_W-1:0] b
  );
    logic [ohist_pkg::ACC_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[ohist_pkg::ACC_W] ? {ohist_pkg::ACC_W{1'b1}} : s[ohist_pkg::ACC_W-1:0];
  endfunction

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_low_q  <= ohist_pkg::RANGE_LOW_RST;
      range_high_q <= ohist_pkg::RANGE_HIGH_RST;
      width_div_q  <= ohist_pkg::WIDTH_DIV_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ohist_pkg::REG_RANGE_LOW:  range_low_q  <= cfg_data_i;
        ohist_pkg::REG_RANGE_HIGH: range_high_q <= cfg_data_i;
        ohist_pkg::REG_WIDTH_DIV:  width_div_q  <= cfg_data_i[ohist_pkg::DIVR_W-1:0];
        default: ;
      endcase
    end
  end

  // Span, its magnitude, and what remains after one bin width; both divide
  // as magnitudes and take their sign back afterwards (truncation to zero).
  // The remainder is split over NUM_BINS - 1 gaps by a reciprocal multiply.
  always_comb begin
    span     = {range_high_q[ohist_pkg::VAL_W-1], range_high_q}
             - {range_low_q[ohist_pkg::VAL_W-1], range_low_q};
    span_neg = span[ohist_pkg::POS_W-1];
    span_abs = span_neg ? (~span + 1'b1) : span;
    rest     = {span[ohist_pkg::POS_W-1], span} - {w_q[ohist_pkg::POS_W-1], w_q};
    rest_neg = rest[ohist_pkg::POS_W];
    rest_abs = rest_neg ? (~rest + 1'b1) : rest;
    step_prod = {{ohist_pkg::STEP_RECIP_W{1'b0}}, rest_abs[ohist_pkg::VAL_W-1:0]}
              * {{ohist_pkg::VAL_W{1'b0}}, ohist_pkg::STEP_RECIP};
    step_mag = {1'b0, step_prod[ohist_pkg::STEP_SHIFT +: ohist_pkg::VAL_W]};
    div_eff  = (width_div_q == '0) ? ohist_pkg::DIVR_W'(1) : width_div_q;
    num      = ohist_pkg::NUM_W'({acc_q[0], {ohist_pkg::FRAC_SHIFT{1'b0}}})
             + ohist_pkg::NUM_W'(total_q >> 1);
    quo_mag  = {1'b0, div_quo[ohist_pkg::VAL_W-1:0]};
  end

  // Divider operands.
  always_comb begin
    case (cmd_i.div_sel)
      ohist_pkg::DIV_SEL_WIDTH: begin
        div_rem   = '0;
        div_dvd   = {span_abs[ohist_pkg::VAL_W-1:0],
                     {(ohist_pkg::DIV_W - ohist_pkg::VAL_W){1'b0}}};
        div_dsr   = ohist_pkg::DIV_W'(div_eff);
        div_steps = ohist_pkg::DIV_STEPS_W'(ohist_pkg::VAL_W);
      end
      ohist_pkg::DIV_SEL_FRAC: begin
        div_rem   = num[ohist_pkg::NUM_W-1 -: ohist_pkg::DIV_W];
        div_dvd   = {num[ohist_pkg::FRAC_W-1:0],
                     {(ohist_pkg::DIV_W - ohist_pkg::FRAC_W){1'b0}}};
        div_dsr   = total_q;
        div_steps = ohist_pkg::DIV_STEPS_W'(ohist_pkg::FRAC_W);
      end
      default: begin
        div_rem   = '0;
        div_dvd   = '0;
        div_dsr   = '0;
        div_steps = '0;
      end
    endcase
  end

  ohist_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .rem_init_i (div_rem),
    .dvd_i      (div_dvd),
    .dsr_i      (div_dsr),
    .steps_i    (div_steps),
    .done_o     (div_done),
    .quo_o      (div_quo)
  );

  // Bin width, start spacing and the running start used while filling.
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_width) begin
      w_q <= span_neg ? (~quo_mag + 1'b1) : quo_mag;
    end
    if (cmd_i.cap_step) begin
      step_q <= rest_neg ? (~step_mag + 1'b1) : step_mag;
    end
    if (cmd_i.fill_reset) begin
      run_q <= {range_low_q[ohist_pkg::VAL_W-1], range_low_q};
    end else if (cmd_i.fill_shift) begin
      run_q <= run_q + step_q;
    end
  end

  // Start line: filled from the top, and rotated once per bin during readout
  // so that the bin being reported always sits at the bottom.
  always_ff @(posedge clk_i) begin
    if (cmd_i.fill_shift || cmd_i.out_load) begin
      for (int j = 0; j < NB - 1; j++) begin
        start_q[j] <= start_q[j+1];
      end
      start_q[NB-1] <= cmd_i.fill_shift ? run_q : start_q[0];
    end
  end

  // Every bin compares the sample against its own half-open range.
  always_comb begin
    logic [ohist_pkg::CMP_W-1:0] v_ext;
    logic [ohist_pkg::CMP_W-1:0] w_ext;
    logic [ohist_pkg::CMP_W-1:0] s_ext;
    logic [ohist_pkg::CMP_W-1:0] e_ext;
    v_ext = {{(ohist_pkg::CMP_W - ohist_pkg::VAL_W){sample_value_i[ohist_pkg::VAL_W-1]}},
             sample_value_i};
    w_ext = {{2{w_q[ohist_pkg::POS_W-1]}}, w_q};
    for (int j = 0; j < NB; j++) begin
      s_ext = {{2{start_q[j][ohist_pkg::POS_W-1]}}, start_q[j]};
      e_ext = s_ext + w_ext;
      if (j == NB - 1) begin
        e_ext = e_ext + ohist_pkg::CMP_W'(ohist_pkg::EDGE_WIDEN);
      end
      hit[j] = ($signed(v_ext) >= $signed(s_ext)) && ($signed(v_ext) < $signed(e_ext));
    end
  end

  // Bin sums shift down during readout and take in zeros, which clears them.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < NB; j++) begin
        acc_q[j] <= '0;
      end
      total_q <= '0;
    end else begin
      if (cmd_i.out_load) begin
        for (int j = 0; j < NB - 1; j++) begin
          acc_q[j] <= acc_q[j+1];
        end
        acc_q[NB-1] <= '0;
      end else if (cmd_i.accum) begin
        for (int j = 0; j < NB; j++) begin
          if (hit[j]) begin
            acc_q[j] <= sat_add(acc_q[j], ohist_pkg::ACC_W'(sample_weight_i));
          end
        end
      end
      if (cmd_i.last_load) begin
        total_q <= '0;
      end else if (cmd_i.accum) begin
        total_q <= sat_add(total_q, ohist_pkg::ACC_W'(sample_weight_i));
      end
    end
  end

  // Bin center (floor of the midpoint) and the rounded, capped fraction.
  always_comb begin
    ctr_sum  = {start_q[0][ohist_pkg::POS_W-1], start_q[0], 1'b0}
             + {{2{w_q[ohist_pkg::POS_W-1]}}, w_q};
    ctr_raw  = ctr_sum[ohist_pkg::CMP_W-1:1];
    if ($signed(ctr_raw) < ohist_pkg::CTR_MIN) begin
      ctr_sat = ohist_pkg::CTR_MIN[ohist_pkg::VAL_W-1:0];
    end else if ($signed(ctr_raw) > ohist_pkg::CTR_MAX) begin
      ctr_sat = ohist_pkg::CTR_MAX[ohist_pkg::VAL_W-1:0];
    end else begin
      ctr_sat = ctr_raw[ohist_pkg::VAL_W-1:0];
    end
    frac_q17 = div_quo[ohist_pkg::FRAC_W-1:0];
    if (total_q == '0) begin
      frac_val = '0;
    end else if (frac_q17 > ohist_pkg::FRAC_ONE) begin
      frac_val = ohist_pkg::FRAC_ONE;
    end else begin
      frac_val = frac_q17;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      bin_number_q   <= cmd_i.bin_idx;
      bin_center_q   <= ctr_sat;
      bin_fraction_q <= frac_val;
      last_bin_q     <= cmd_i.last_load;
    end
  end

  assign sts_o.div_done = div_done;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o    = out_valid_q;
  assign bin_number_o   = bin_number_q;
  assign bin_center_o   = bin_center_q;
  assign bin_fraction_o = bin_fraction_q;
  assign last_bin_o     = last_bin_q;

endmodule

`default_nettype wire

FILE: rtl/ohist_ctrl.sv
// Controller: bin table rebuild, sample intake and per-bin readout sequencing.
// Depends on ohist_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module ohist_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic            in_valid_i,
  input  logic            last_sample_i,
  output logic            in_ready_o,
  input  ohist_pkg::sts_t sts_i,
  output ohist_pkg::cmd_t cmd_o
);

  localparam logic [3:0] ST_WIDTH_GO  = 4'd0;
  localparam logic [3:0] ST_WIDTH_RUN = 4'd1;
  localparam logic [3:0] ST_STEP      = 4'd2;
  localparam logic [3:0] ST_FILL      = 4'd4;
  localparam logic [3:0] ST_IDLE      = 4'd5;
  localparam logic [3:0] ST_FRAC_GO   = 4'd6;
  localparam logic [3:0] ST_FRAC_RUN  = 4'd7;
  localparam logic [3:0] ST_FRAC_HOLD = 4'd8;

  localparam logic [ohist_pkg::BIN_IDX_W-1:0] LAST_BIN =
    ohist_pkg::BIN_IDX_W'(ohist_pkg::NUM_BINS - 1);
  localparam logic [ohist_pkg::CNT_W-1:0] LAST_CNT =
    ohist_pkg::CNT_W'(ohist_pkg::MAX_SAMPLES - 1);

  logic [3:0]                        state_q, state_d;
  logic [ohist_pkg::BIN_IDX_W-1:0]   bin_q, bin_d;
  logic [ohist_pkg::CNT_W-1:0]       cnt_q, cnt_d;
  logic                              ready;

  always_comb begin
    state_d = state_q;
    bin_d   = bin_q;
    cnt_d   = cnt_q;
    ready   = 1'b0;
    cmd_o   = '0;
    cmd_o.div_sel = ohist_pkg::DIV_SEL_FRAC;
    cmd_o.bin_idx = bin_q;

    case (state_q)
      ST_WIDTH_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = ohist_pkg::DIV_SEL_WIDTH;
        state_d         = ST_WIDTH_RUN;
      end
      ST_WIDTH_RUN: begin
        cmd_o.div_sel = ohist_pkg::DIV_SEL_WIDTH;
        if (sts_i.div_done) begin
          cmd_o.cap_width = 1'b1;
          state_d         = ST_STEP;
        end
      end
      ST_STEP: begin
        cmd_o.cap_step   = 1'b1;
        cmd_o.fill_reset = 1'b1;
        bin_d            = '0;
        state_d          = ST_FILL;
      end
      ST_FILL: begin
        cmd_o.fill_shift = 1'b1;
        if (bin_q == LAST_BIN) begin
          bin_d   = '0;
          state_d = ST_IDLE;
        end else begin
          bin_d = bin_q + 1'b1;
        end
      end
      ST_IDLE: begin
        ready = 1'b1;
        if (in_valid_i) begin
          cmd_o.accum = 1'b1;
          if (last_sample_i || (cnt_q == LAST_CNT)) begin
            cnt_d   = '0;
            bin_d   = '0;
            state_d = ST_FRAC_GO;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
      end
      ST_FRAC_GO: begin
        cmd_o.div_start = 1'b1;
        state_d         = ST_FRAC_RUN;
      end
      ST_FRAC_RUN: begin
        if (sts_i.div_done) begin
          state_d = ST_FRAC_HOLD;
        end
      end
      ST_FRAC_HOLD: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          if (bin_q == LAST_BIN) begin
            cmd_o.last_load = 1'b1;
            bin_d           = '0;
            state_d         = ST_IDLE;
          end else begin
            bin_d   = bin_q + 1'b1;
            state_d = ST_FRAC_GO;
          end
        end
      end
      default: begin
        state_d = ST_WIDTH_GO;
      end
    endcase

    // Any register write rebuilds the bin table from the start.
    if (cfg_we_i) begin
      state_d = ST_WIDTH_GO;
      bin_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_WIDTH_GO;
      bin_q   <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      bin_q   <= bin_d;
      cnt_q   <= cnt_d;
    end
  end

  assign in_ready_o = ready;

endmodule

`default_nettype wire

FILE: rtl/overlapping_bin_weighted_histogram.sv
// Top level of the overlapping-bin weighted histogram.
// Joins ohist_ctrl and ohist_dp; depends on ohist_pkg, ohist_ctrl, ohist_dp, ohist_div.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                 Payload
// ------------------------------------------------------------------------------
// sample    in         in_valid_i / in_ready_o   sample_value_i, sample_weight_i,
//                                                last_sample_i
// bin       out        out_valid_o / out_ready_i bin_number_o, bin_center_o,
//                                                bin_fraction_o, last_bin_o
// config    in         cfg_we_i (no wait)        cfg_idx_i, cfg_data_i
//
// A sample that does not close its set leaves the intake open for the next one:
// every bin cell checks its range and adds the weight in the same cycle. A closing
// sample starts the readout, which runs the shared bit-serial divider once per bin,
// with 17 divider steps a bin.
// After reset and after every register write the bin table is rebuilt: one
// 20-step division, the start spacing and a fill of all 64 bin starts, all with
// in_ready_o low.
// A stalled bin transfer holds the readout; once the last bin sits in the output
// register, samples of the next set are taken while it waits.

module overlapping_bin_weighted_histogram (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [ohist_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [ohist_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [ohist_pkg::VAL_W-1:0]          sample_value_i,
  input  logic [ohist_pkg::WT_W-1:0]           sample_weight_i,
  input  logic                                 last_sample_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [ohist_pkg::BIN_IDX_W-1:0]      bin_number_o,
  output logic [ohist_pkg::VAL_W-1:0]          bin_center_o,
  output logic [ohist_pkg::FRAC_W-1:0]         bin_fraction_o,
  output logic                                 last_bin_o
);

  ohist_pkg::cmd_t cmd;
  ohist_pkg::sts_t sts;

  // The controller owns sequencing; the datapath owns all arithmetic and storage.
  ohist_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .in_valid_i    (in_valid_i),
    .last_sample_i (last_sample_i),
    .in_ready_o    (in_ready_o),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  ohist_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .sample_value_i  (sample_value_i),
    .sample_weight_i (sample_weight_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_ready_i     (out_ready_i),
    .out_valid_o     (out_valid_o),
    .bin_number_o    (bin_number_o),
    .bin_center_o    (bin_center_o),
    .bin_fraction_o  (bin_fraction_o),
    .last_bin_o      (last_bin_o)
  );

  // A register write always starts a rebuild, during which no sample is taken.
  a_cfg_blocks_intake: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> !in_ready_o
  ) else $error("sample intake open right after a register write");

  // The controller never loads a bin over one that has not been transferred.
  a_load_into_free_slot: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> sts.out_free
  ) else $error("output register overwritten before its transfer");

  // Samples are only summed while the readout is not using the bin cells.
  a_no_accum_in_readout: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    cmd.accum |-> (in_ready_o && !cmd.out_load && !cmd.fill_shift)
  ) else $error("sample summed while bins were shifting");

  // A fraction never exceeds one.
  a_fraction_bound: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (bin_fraction_o <= ohist_pkg::FRAC_ONE)
  ) else $error("bin fraction above one");

endmodule

`default_nettype wire
